/* rtl/core/qts_pkg.sv */
// Shared types, character codes and helpers for the quoted token splitter.
`timescale 1ns / 1ps

package qts_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [1:0] SEP_NONE   = 2'd0;
    localparam logic [1:0] SEP_COMMA  = 2'd1;
    localparam logic [1:0] SEP_EQUALS = 2'd2;

    typedef enum logic [1:0] {
        MODE_WS    = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_QUOTE = 2'd2,
        MODE_SEP   = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] token_byte;
        logic       token_done;
        logic [1:0] separator_kind;
        logic       line_done;
        logic       line_ok;
    } t_out_item;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [1:0] sep_code(input logic [7:0] c);
        logic [1:0] s;
        s = SEP_NONE;
        if (c == CH_COMMA) begin
            s = SEP_COMMA;
        end else if (c == CH_EQUALS) begin
            s = SEP_EQUALS;
        end
        return s;
    endfunction

endpackage

/* rtl/core/qts_scan.sv */
// Tokenizer state machine: scan mode, line-finished flag and per-byte result.
`timescale 1ns / 1ps

module qts_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  qts_pkg::t_in_item    i_item,
    output qts_pkg::t_out_item   o_result
);

    qts_pkg::t_scan_mode r_mode, n_mode;
    logic                r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qts_pkg::MODE_WS;
            r_fin  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_fin  <= n_fin;
        end
    end

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic [1:0] s;
        logic       err;
        logic       end_line;

        c        = i_item.char_code;
        last     = i_item.last_char;
        s        = qts_pkg::sep_code(c);
        err      = 1'b0;
        end_line = 1'b0;
        n_mode   = r_mode;
        n_fin    = r_fin;
        o_result = '0;

        if (r_fin) begin
            // drop bytes until the line's last one
            if (last) begin
                n_fin  = 1'b0;
                n_mode = qts_pkg::MODE_WS;
            end
        end else begin
            if ((c == qts_pkg::CH_NUL) || (c == qts_pkg::CH_NEWLINE)) begin
                end_line = 1'b1;
            end else begin
                case (r_mode)
                    qts_pkg::MODE_WS: begin
                        if (!qts_pkg::is_blank(c)) begin
                            if (s != qts_pkg::SEP_NONE) begin
                                err = 1'b1;
                            end else if (c == qts_pkg::CH_QUOTE) begin
                                n_mode = qts_pkg::MODE_QUOTE;
                            end else begin
                                n_mode              = qts_pkg::MODE_PLAIN;
                                o_result.byte_valid = 1'b1;
                                o_result.token_byte = c;
                            end
                        end
                    end
                    qts_pkg::MODE_PLAIN: begin
                        if (c == qts_pkg::CH_QUOTE) begin
                            err = 1'b1;
                        end else if (s != qts_pkg::SEP_NONE) begin
                            o_result.token_done     = 1'b1;
                            o_result.separator_kind = s;
                            n_mode                  = qts_pkg::MODE_WS;
                        end else if (qts_pkg::is_blank(c)) begin
                            n_mode = qts_pkg::MODE_SEP;
                        end else begin
                            o_result.byte_valid = 1'b1;
                            o_result.token_byte = c;
                        end
                    end
                    qts_pkg::MODE_QUOTE: begin
                        if (c == qts_pkg::CH_QUOTE) begin
                            n_mode = qts_pkg::MODE_SEP;
                        end else begin
                            o_result.byte_valid = 1'b1;
                            o_result.token_byte = c;
                        end
                    end
                    default: begin
                        if (s != qts_pkg::SEP_NONE) begin
                            o_result.token_done     = 1'b1;
                            o_result.separator_kind = s;
                            n_mode                  = qts_pkg::MODE_WS;
                        end else if (!qts_pkg::is_blank(c)) begin
                            err = 1'b1;
                        end
                    end
                endcase
                if (!err && last) begin
                    end_line = 1'b1;
                end
            end

            if (err) begin
                o_result.line_done = 1'b1;
                o_result.line_ok   = 1'b0;
            end else if (end_line) begin
                // close any open token against the mode just reached
                o_result.line_done = 1'b1;
                case (n_mode)
                    qts_pkg::MODE_PLAIN, qts_pkg::MODE_SEP: begin
                        o_result.token_done     = 1'b1;
                        o_result.separator_kind = qts_pkg::SEP_NONE;
                        o_result.line_ok        = 1'b1;
                    end
                    qts_pkg::MODE_QUOTE: begin
                        o_result.line_ok = 1'b0;
                    end
                    default: begin
                        o_result.line_ok = 1'b1;
                    end
                endcase
            end

            if (o_result.line_done) begin
                n_mode = qts_pkg::MODE_WS;
                n_fin  = !last;
            end
        end
    end

endmodule

/* rtl/core/qts_out_reg.sv */
// Result register holding one result until its transfer completes.
`timescale 1ns / 1ps

module qts_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  qts_pkg::t_out_item   i_result,
    input  logic                 i_stall,
    output logic                 o_free,
    output logic                 o_valid,
    output qts_pkg::t_out_item   o_item
);

    logic               r_valid;
    qts_pkg::t_out_item r_item;

    // space when empty or when the held result leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/quoted_token_splitter.sv */
// Quoted token splitter: input register, tokenizer and result register.
// A byte's transfer is taken into the input register; its result is then
// registered in the result register, which offers it. Throughput: one byte
// per cycle while the output flows; both stages advance together.
// Reset (synchronous, active low) empties both stages and returns the
// tokenizer to whitespace mode with a fresh line.
`timescale 1ns / 1ps

module quoted_token_splitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  qts_pkg::t_in_item    i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output qts_pkg::t_out_item   o_item
);

    logic               r_in_valid;
    qts_pkg::t_in_item  r_in_item;
    logic               out_free;
    logic               step;
    qts_pkg::t_out_item scan_result;

    assign step    = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_item <= i_item;
        end
    end

    qts_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (scan_result)
    );

    qts_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (scan_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("processed byte did not reach the result register");

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.line_ok) |-> o_item.line_done)
        else $error("line_ok without line_done");

    a_sep_needs_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.separator_kind != qts_pkg::SEP_NONE)) |-> o_item.token_done)
        else $error("separator reported without a completed token");

endmodule
